>>> design/ptdp_pkg.sv
// Shared constants and types for the packed ternary dot product block.
package ptdp_pkg;

  localparam int ACC_WIDTH_DEF = 48;
  localparam int ACT_W         = 8;
  localparam int BYTE_W        = 8;
  localparam int CNT_W         = 3;
  localparam int DOT_W         = 48;
  localparam int TALLY_W       = 32;
  localparam int NTRITS        = 5;
  localparam int NTRITS_TWO    = 4;
  localparam int DIGIT_W       = 2;
  localparam int PROD_W        = 10;
  localparam int SUM_W         = 12;
  localparam int EXT_W         = 64;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // Register index taken from the word-aligned APB address.
  localparam logic REG_PACKING_FORMAT = 1'b0;

  localparam logic FMT_BASE243 = 1'b0;
  localparam logic FMT_TWO_BIT = 1'b1;

  localparam logic [CNT_W-1:0] CAP_BASE243 = 3'd5;
  localparam logic [CNT_W-1:0] CAP_TWO_BIT = 3'd4;

  // One classified word, as handed from the front end to the accumulator.
  typedef struct packed {
    logic signed [SUM_W-1:0] p_total;
    logic [CNT_W-1:0]        cnt;
    logic                    last;
  } entry_t;

endpackage

>>> design/ptdp_if.sv
// Valid/ready channel interfaces for the input words and the result words.
interface ptdp_in_if;
  logic                                valid;
  logic                                ready;
  logic [ptdp_pkg::BYTE_W-1:0]         packed_byte;
  logic signed [ptdp_pkg::ACT_W-1:0]   act_zero;
  logic signed [ptdp_pkg::ACT_W-1:0]   act_one;
  logic signed [ptdp_pkg::ACT_W-1:0]   act_two;
  logic signed [ptdp_pkg::ACT_W-1:0]   act_three;
  logic signed [ptdp_pkg::ACT_W-1:0]   act_four;
  logic [ptdp_pkg::CNT_W-1:0]          valid_trits;
  logic                                last_item;

  modport source (
    output valid, packed_byte, act_zero, act_one, act_two, act_three, act_four,
           valid_trits, last_item,
    input  ready
  );
  modport sink (
    input  valid, packed_byte, act_zero, act_one, act_two, act_three, act_four,
           valid_trits, last_item,
    output ready
  );
endinterface

interface ptdp_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [ptdp_pkg::DOT_W-1:0]   dot_sum;
  logic [ptdp_pkg::TALLY_W-1:0]        trits_used;

  modport source (output valid, dot_sum, trits_used, input ready);
  modport sink (input valid, dot_sum, trits_used, output ready);
endinterface

>>> design/packed_ternary_dot_product.sv
// Packed ternary dot product: accumulates weight-times-activation over a stream of words.
//
// Input words arrive on in_chan (valid/ready). Each carries one packed weight
// byte, five signed activations, a count of leading trits to use and a last
// flag. The packing register at APB address 0 selects base-243 (five trits per
// byte) or two-bit (four trits per byte) unpacking; write it only while idle.
// On a word flagged last, one result word leaves on out_chan with the
// saturated sum and the trit count, and both are cleared for the next vector.
// Throughput is one word per cycle while the queue has room, set by the
// accumulator loop. The final input word passes through the front register,
// the queue and the result register in turn before its result word is
// valid. When the receiver holds out_chan.ready low, non-final words keep
// draining into the accumulator and a final word waits in the two-entry
// queue; in_chan.ready drops only when the queue and the front register are
// both full. Reset clears the accumulator, the tally, the queue and the
// packing register (base-243).
module packed_ternary_dot_product #(
  parameter int ACC_WIDTH = ptdp_pkg::ACC_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  ptdp_in_if.sink                        in_chan,
  ptdp_out_if.source                     out_chan,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ptdp_pkg::PADDR_W-1:0]   paddr,
  input  logic [ptdp_pkg::PDATA_W-1:0]   pwdata,
  output logic [ptdp_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);

  localparam int QW = 2 * ACC_WIDTH + $bits(ptdp_pkg::entry_t);

  logic                        fmt_r;
  logic                        cfg_wr;
  logic                        q_push;
  logic                        q_full;
  logic                        q_pop;
  logic                        q_valid;
  ptdp_pkg::entry_t            f_entry;
  ptdp_pkg::entry_t            b_entry;
  logic signed [ACC_WIDTH-1:0] f_hi;
  logic signed [ACC_WIDTH-1:0] f_lo;
  logic signed [ACC_WIDTH-1:0] b_hi;
  logic signed [ACC_WIDTH-1:0] b_lo;
  logic [QW-1:0]               q_wdata;
  logic [QW-1:0]               q_rdata;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready
                  && (paddr[ptdp_pkg::PADDR_W-1] == ptdp_pkg::REG_PACKING_FORMAT);
  assign prdata = (paddr[ptdp_pkg::PADDR_W-1] == ptdp_pkg::REG_PACKING_FORMAT)
                  ? {{(ptdp_pkg::PDATA_W-1){1'b0}}, fmt_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= ptdp_pkg::FMT_BASE243;
    end else if (cfg_wr) begin
      fmt_r <= pwdata[0];
    end
  end

  ptdp_front #(.ACC_WIDTH(ACC_WIDTH)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .fmt      (fmt_r),
    .in_chan  (in_chan),
    .q_push   (q_push),
    .q_full   (q_full),
    .q_entry  (f_entry),
    .hi_bound (f_hi),
    .lo_bound (f_lo)
  );

  assign q_wdata = {f_hi, f_lo, f_entry};

  ptdp_queue #(.W(QW)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .valid (q_valid)
  );

  assign {b_hi, b_lo, b_entry} = q_rdata;

  ptdp_back #(.ACC_WIDTH(ACC_WIDTH)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_entry  (b_entry),
    .hi_bound (b_hi),
    .lo_bound (b_lo),
    .q_pop    (q_pop),
    .out_chan (out_chan)
  );

`ifndef ASSERT_OFF
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("accumulator drained an empty queue");

  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && b_entry.last) |=> out_chan.valid)
    else $error("final word drained without a result word");

  a_taken_result_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.ready && !(q_pop && b_entry.last)) |=> !out_chan.valid)
    else $error("result word repeated after it was taken");

  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    (q_full && !q_pop) |=> q_full)
    else $error("queue lost an entry while full");
`endif

endmodule

>>> design/ptdp_front.sv
// Front end: accepts words, unpacks the weight digits and forms the products.
module ptdp_front #(
  parameter int ACC_WIDTH = ptdp_pkg::ACC_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        fmt,
  ptdp_in_if.sink                     in_chan,
  output logic                        q_push,
  input  logic                        q_full,
  output ptdp_pkg::entry_t            q_entry,
  output logic signed [ACC_WIDTH-1:0] hi_bound,
  output logic signed [ACC_WIDTH-1:0] lo_bound
);

  localparam logic signed [ACC_WIDTH-1:0] ACC_HI = {1'b0, {(ACC_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_WIDTH-1:0] ACC_LO = {1'b1, {(ACC_WIDTH-1){1'b0}}};
  localparam logic [ptdp_pkg::BYTE_W-1:0] POW3 [ptdp_pkg::NTRITS] =
    '{8'd1, 8'd3, 8'd9, 8'd27, 8'd81};
  localparam logic [ptdp_pkg::BYTE_W-1:0] FULL243 = 8'd243;

  typedef logic [ptdp_pkg::NTRITS-1:0][ptdp_pkg::DIGIT_W-1:0] digits_t;

  // Base-243 digits by compare and subtract from the top digit down. Bytes at
  // or above 243 share their low five digits with byte minus 243, since 243 is
  // a multiple of every lower power of three, and their top digit is zero.
  function automatic digits_t b243_digits(input logic [ptdp_pkg::BYTE_W-1:0] b);
    logic [ptdp_pkg::BYTE_W:0] r;
    digits_t d;
    r = {1'b0, b};
    d = '0;
    if (b >= FULL243) begin
      r = {1'b0, b - FULL243};
    end
    for (int k = ptdp_pkg::NTRITS - 1; k >= 0; k--) begin
      if (r >= {POW3[k], 1'b0}) begin
        d[k] = 2'd2;
        r = r - {POW3[k], 1'b0};
      end else if (r >= {1'b0, POW3[k]}) begin
        d[k] = 2'd1;
        r = r - {1'b0, POW3[k]};
      end
    end
    return d;
  endfunction

  // Weight is digit minus one, so the product is a negate, a zero, a copy or
  // a doubling of the activation.
  function automatic logic signed [ptdp_pkg::PROD_W-1:0] trit_prod(
    input logic [ptdp_pkg::DIGIT_W-1:0]     d,
    input logic signed [ptdp_pkg::ACT_W-1:0] a
  );
    logic signed [ptdp_pkg::PROD_W-1:0] a_ext;
    logic signed [ptdp_pkg::PROD_W-1:0] p;
    a_ext = ptdp_pkg::PROD_W'(a);
    case (d)
      2'd0:    p = -a_ext;
      2'd1:    p = '0;
      2'd2:    p = a_ext;
      default: p = a_ext <<< 1;
    endcase
    return p;
  endfunction

  logic                                f_valid_r;
  logic signed [ptdp_pkg::PROD_W-1:0]  f_prod_r [ptdp_pkg::NTRITS];
  logic signed [ptdp_pkg::PROD_W-1:0]  f_prod_nxt [ptdp_pkg::NTRITS];
  logic [ptdp_pkg::CNT_W-1:0]          f_cnt_r;
  logic [ptdp_pkg::CNT_W-1:0]          f_cnt_nxt;
  logic                                f_last_r;
  logic                                accept;
  digits_t                             d243;
  digits_t                             dsel;
  logic signed [ptdp_pkg::ACT_W-1:0]   act [ptdp_pkg::NTRITS];
  logic [ptdp_pkg::CNT_W-1:0]          cap;
  logic signed [ptdp_pkg::SUM_W-1:0]   run;
  logic signed [ptdp_pkg::SUM_W-1:0]   run_max;
  logic signed [ptdp_pkg::SUM_W-1:0]   run_min;

  assign q_push        = f_valid_r && !q_full;
  assign in_chan.ready = !f_valid_r || !q_full;
  assign accept        = in_chan.valid && in_chan.ready;

  assign act[0] = in_chan.act_zero;
  assign act[1] = in_chan.act_one;
  assign act[2] = in_chan.act_two;
  assign act[3] = in_chan.act_three;
  assign act[4] = in_chan.act_four;

  always_comb begin
    d243 = b243_digits(in_chan.packed_byte);
    dsel = d243;
    cap  = ptdp_pkg::CAP_BASE243;
    if (fmt == ptdp_pkg::FMT_TWO_BIT) begin
      cap = ptdp_pkg::CAP_TWO_BIT;
      for (int k = 0; k < ptdp_pkg::NTRITS_TWO; k++) begin
        dsel[k] = in_chan.packed_byte[ptdp_pkg::DIGIT_W*k +: ptdp_pkg::DIGIT_W];
      end
      dsel[ptdp_pkg::NTRITS-1] = 2'd1;
    end
    f_cnt_nxt = (in_chan.valid_trits > cap) ? cap : in_chan.valid_trits;
    for (int k = 0; k < ptdp_pkg::NTRITS; k++) begin
      f_prod_nxt[k] = (ptdp_pkg::CNT_W'(k) < f_cnt_nxt) ? trit_prod(dsel[k], act[k]) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else if (accept) begin
      f_valid_r <= 1'b1;
    end else if (q_push) begin
      f_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int k = 0; k < ptdp_pkg::NTRITS; k++) begin
        f_prod_r[k] <= f_prod_nxt[k];
      end
      f_cnt_r  <= f_cnt_nxt;
      f_last_r <= in_chan.last_item;
    end
  end

  // Running prefix sums with their extremes; the accumulator uses these to
  // apply the per-product clamp in a single step.
  always_comb begin
    run     = '0;
    run_max = '0;
    run_min = '0;
    for (int k = 0; k < ptdp_pkg::NTRITS; k++) begin
      run = run + ptdp_pkg::SUM_W'(f_prod_r[k]);
      if (run > run_max) begin
        run_max = run;
      end
      if (run < run_min) begin
        run_min = run;
      end
    end
    q_entry.p_total = run;
    q_entry.cnt     = f_cnt_r;
    q_entry.last    = f_last_r;
    hi_bound        = ACC_HI - ACC_WIDTH'(run_max);
    lo_bound        = ACC_LO - ACC_WIDTH'(run_min);
  end

endmodule

>>> design/ptdp_queue.sv
// Two-entry queue between the front end and the accumulator.
module ptdp_queue #(
  parameter int W = 1
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         valid
);

  logic [W-1:0]                  mem_r [ptdp_pkg::QDEPTH];
  logic [ptdp_pkg::QPTR_W-1:0]   wr_ptr_r;
  logic [ptdp_pkg::QPTR_W-1:0]   rd_ptr_r;
  logic [ptdp_pkg::QCNT_W-1:0]   cnt_r;
  logic [ptdp_pkg::QCNT_W-1:0]   cnt_nxt;

  localparam logic [ptdp_pkg::QCNT_W-1:0] QFULL = ptdp_pkg::QCNT_W'(ptdp_pkg::QDEPTH);

  assign full  = (cnt_r == QFULL);
  assign valid = (cnt_r != '0);
  assign rdata = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

>>> design/ptdp_back.sv
// Back end: saturating accumulator, trit tally and the result register.
module ptdp_back #(
  parameter int ACC_WIDTH = ptdp_pkg::ACC_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_valid,
  input  ptdp_pkg::entry_t            q_entry,
  input  logic signed [ACC_WIDTH-1:0] hi_bound,
  input  logic signed [ACC_WIDTH-1:0] lo_bound,
  output logic                        q_pop,
  ptdp_out_if.source                  out_chan
);

  logic signed [ACC_WIDTH-1:0]          acc_r;
  logic signed [ACC_WIDTH-1:0]          acc_nxt;
  logic signed [ACC_WIDTH-1:0]          acc_sel;
  logic signed [ACC_WIDTH-1:0]          acc_sum;
  logic signed [ptdp_pkg::EXT_W-1:0]    acc_ext;
  logic [ptdp_pkg::TALLY_W-1:0]         tally_r;
  logic [ptdp_pkg::TALLY_W-1:0]         tally_nxt;
  logic [ptdp_pkg::TALLY_W-1:0]         tally_sum;
  logic [ptdp_pkg::TALLY_W:0]           tally_wide;
  logic                                 out_valid_r;
  logic                                 out_valid_nxt;
  logic signed [ptdp_pkg::DOT_W-1:0]    dot_r;
  logic [ptdp_pkg::TALLY_W-1:0]         used_r;

  // A non-final word never needs the result register, so it drains freely.
  assign q_pop = q_valid && (!q_entry.last || !out_valid_r || out_chan.ready);

  always_comb begin
    // Clamping the starting value against the prefix extremes and then adding
    // the word total equals clamping after every single product.
    if (acc_r > hi_bound) begin
      acc_sel = hi_bound;
    end else if (acc_r < lo_bound) begin
      acc_sel = lo_bound;
    end else begin
      acc_sel = acc_r;
    end
    acc_sum    = acc_sel + ACC_WIDTH'(q_entry.p_total);
    acc_ext    = ptdp_pkg::EXT_W'(acc_sum);
    tally_wide = {1'b0, tally_r} + (ptdp_pkg::TALLY_W + 1)'(q_entry.cnt);
    tally_sum  = tally_wide[ptdp_pkg::TALLY_W] ? '1 : tally_wide[ptdp_pkg::TALLY_W-1:0];
    acc_nxt    = q_entry.last ? '0 : acc_sum;
    tally_nxt  = q_entry.last ? '0 : tally_sum;

    out_valid_nxt = out_valid_r;
    if (q_pop && q_entry.last) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      tally_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        acc_r   <= acc_nxt;
        tally_r <= tally_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_entry.last) begin
      dot_r  <= acc_ext[ptdp_pkg::DOT_W-1:0];
      used_r <= tally_sum;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.dot_sum    = dot_r;
  assign out_chan.trits_used = used_r;

endmodule
